### hdl/e2q_pkg.sv
// Package: shared constants, types and functions for the Euler-to-quaternion core.
`timescale 1ns / 1ps
package e2q_pkg;
  localparam int ANGLE_BITS = 16;
  localparam int COMPONENT_BITS = 16;
  localparam int N_LANES = 6;
  localparam int HORNER_STEPS = 6;
  localparam int N_STAGES = HORNER_STEPS + 4;

  typedef logic [29:0] q30u_t;
  typedef logic signed [31:0] q30s_t;

  function automatic logic [31:0] sin_coef(input logic [2:0] k);
    logic [31:0] c;
    c = 32'd0;
    unique case (k)
      3'd0: c = 32'd1686629713;
      3'd1: c = 32'd693598668;
      3'd2: c = 32'd85569306;
      3'd3: c = 32'd5026995;
      3'd4: c = 32'd172272;
      3'd5: c = 32'd3864;
      3'd6: c = 32'd61;
      default: c = 32'd0;
    endcase
    return c;
  endfunction

  function automatic logic [31:0] half_phase(input logic [ANGLE_BITS-1:0] a);
    logic [63:0] v;
    v = 64'(signed'(a));
    if (31 - ANGLE_BITS >= 0) v = v << (31 - ANGLE_BITS);
    else v = v >> (ANGLE_BITS - 31);
    return v[31:0];
  endfunction
endpackage

### hdl/euler_to_quaternion_core.sv
// Top level: Euler angles (XYZ) to unit quaternion, six sine lanes and a merge stage.
// channel | dir | handshake          | fields
// in      | in  | in_valid/in_stall  | angle_x, angle_y, angle_z
// out     | out | out_valid/out_stall| quat_x, quat_y, quat_z, quat_w
// One beat per cycle while the output is not stalled; the pipeline is the nine sine
// lane stages followed by the three merge stages. The whole pipeline advances when
// the output is not stalled or its slot is empty. Reset clears the valid bits only.
`timescale 1ns / 1ps
module euler_to_quaternion_core (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  logic signed [e2q_pkg::ANGLE_BITS-1:0] angle_x_i,
  input  logic signed [e2q_pkg::ANGLE_BITS-1:0] angle_y_i,
  input  logic signed [e2q_pkg::ANGLE_BITS-1:0] angle_z_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output logic signed [e2q_pkg::COMPONENT_BITS-1:0] quat_x_o,
  output logic signed [e2q_pkg::COMPONENT_BITS-1:0] quat_y_o,
  output logic signed [e2q_pkg::COMPONENT_BITS-1:0] quat_z_o,
  output logic signed [e2q_pkg::COMPONENT_BITS-1:0] quat_w_o
);
  localparam int L = e2q_pkg::N_STAGES + 2;
  logic [L-1:0] v_q;
  logic en;
  logic [31:0] ph [0:5];
  logic signed [31:0] sc [0:5];
  logic [e2q_pkg::COMPONENT_BITS-1:0] q [0:3];

  assign en = !out_valid_o || !out_stall_i;
  assign in_stall_o = !en;
  assign out_valid_o = v_q[L-1];

  always_comb begin
    ph[0] = e2q_pkg::half_phase(angle_x_i);
    ph[2] = e2q_pkg::half_phase(angle_y_i);
    ph[4] = e2q_pkg::half_phase(angle_z_i);
    ph[1] = ph[0] + 32'h40000000;
    ph[3] = ph[2] + 32'h40000000;
    ph[5] = ph[4] + 32'h40000000;
  end

  for (genvar i = 0; i < e2q_pkg::N_LANES; i++) begin : g_lane
    e2q_sin_lane u_lane (.clk_i(clk_i), .en_i(en), .phase_i(ph[i]), .sin_o(sc[i]));
  end

  e2q_merge u_merge (.clk_i(clk_i), .en_i(en), .sc_i(sc), .q_o(q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[L-2:0], in_valid_i};
    end
  end

  assign quat_x_o = q[0];
  assign quat_y_o = q[1];
  assign quat_z_o = q[2];
  assign quat_w_o = q[3];
endmodule

### hdl/e2q_sin_lane.sv
// Sine lane: pipelined quadrant reduction and Horner series, one phase per cycle while en_i is high.
`timescale 1ns / 1ps
module e2q_sin_lane (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [31:0]  phase_i,
  output logic signed [31:0] sin_o
);
  localparam int S = e2q_pkg::HORNER_STEPS;
  logic [30:0] r_q   [0:S+1];
  logic [1:0]  quad_q[0:S+1];
  logic [31:0] u2_q  [0:S];
  logic [31:0] t_q   [0:S];
  logic signed [31:0] res_q;
  logic [61:0] rr;
  logic [63:0] ut [0:S-1];
  logic [63:0] mt;
  logic [30:0] rin;

  assign rin = phase_i[30] ? (31'h40000000 - {1'b0, phase_i[29:0]}) : {1'b0, phase_i[29:0]};
  assign rr = 62'(r_q[0]) * 62'(r_q[0]);

  always_comb begin
    for (int i = 0; i < S; i++) begin
      ut[i] = 64'(u2_q[i]) * 64'(t_q[i]);
    end
    mt = 64'(r_q[S+1]) * 64'(t_q[S]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0] <= rin;
      quad_q[0] <= phase_i[31:30];
      r_q[1] <= r_q[0];
      quad_q[1] <= quad_q[0];
      u2_q[0] <= 32'(rr >> 30);
      t_q[0] <= e2q_pkg::sin_coef(3'd6);
      for (int i = 0; i < S; i++) begin
        r_q[i+2] <= r_q[i+1];
        quad_q[i+2] <= quad_q[i+1];
        u2_q[i+1] <= u2_q[i];
        t_q[i+1] <= e2q_pkg::sin_coef(3'(S-1-i)) - 32'(ut[i] >> 30);
      end
      res_q <= quad_q[S+1][1] ? -signed'(32'(mt >> 30)) : signed'(32'(mt >> 30));
    end
  end
  assign sin_o = res_q;
endmodule

### hdl/e2q_merge.sv
// Merge stage: products of the lane sines and cosines, rounding and saturation.
`timescale 1ns / 1ps
module e2q_merge (
  input  logic clk_i,
  input  logic en_i,
  input  logic signed [31:0] sc_i [0:5],
  output logic [e2q_pkg::COMPONENT_BITS-1:0] q_o [0:3]
);
  localparam int CB = e2q_pkg::COMPONENT_BITS;
  logic signed [31:0] sc_q, ss_q, cs_q, cc_q, sz_q, cz_q;
  logic signed [31:0] p_q [0:7];
  logic [CB-1:0] q_q [0:3];

  function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic [31:0] ua, ub;
    logic [63:0] p;
    ua = a[31] ? 32'(-a) : 32'(a);
    ub = b[31] ? 32'(-b) : 32'(b);
    p = (64'(ua) * 64'(ub)) >> 30;
    return (a[31] != b[31]) ? -signed'(p[31:0]) : signed'(p[31:0]);
  endfunction

  function automatic logic [CB-1:0] to_comp(input logic signed [33:0] v);
    logic [33:0] mag;
    logic [63:0] m;
    logic [63:0] maxp;
    logic [CB-1:0] r;
    mag = v[33] ? 34'(-v) : 34'(v);
    m = 64'(mag);
    if (31 - CB > 0) m = (m + (64'd1 << (30 - CB))) >> (31 - CB);
    else m = m << (CB - 31);
    maxp = (64'd1 << (CB - 1)) - 64'd1;
    if (v[33]) r = (m > maxp + 64'd1) ? CB'(maxp + 64'd1) : CB'(-m);
    else r = (m > maxp) ? CB'(maxp) : CB'(m);
    return r;
  endfunction

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sc_q <= mulq(sc_i[0], sc_i[3]);
      ss_q <= mulq(sc_i[0], sc_i[2]);
      cs_q <= mulq(sc_i[1], sc_i[2]);
      cc_q <= mulq(sc_i[1], sc_i[3]);
      sz_q <= sc_i[4];
      cz_q <= sc_i[5];
      p_q[0] <= mulq(sc_q, cz_q);
      p_q[1] <= mulq(cs_q, sz_q);
      p_q[2] <= mulq(cs_q, cz_q);
      p_q[3] <= mulq(sc_q, sz_q);
      p_q[4] <= mulq(cc_q, sz_q);
      p_q[5] <= mulq(ss_q, cz_q);
      p_q[6] <= mulq(cc_q, cz_q);
      p_q[7] <= mulq(ss_q, sz_q);
      q_q[0] <= to_comp(34'(p_q[0]) - 34'(p_q[1]));
      q_q[1] <= to_comp(34'(p_q[2]) + 34'(p_q[3]));
      q_q[2] <= to_comp(34'(p_q[4]) - 34'(p_q[5]));
      q_q[3] <= to_comp(34'(p_q[6]) + 34'(p_q[7]));
    end
  end
  assign q_o = q_q;
endmodule

### hdl/e2q_checker.sv
// Checker: port-level properties of the Euler-to-quaternion core, bound to the top.
`timescale 1ns / 1ps
module e2q_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic [15:0] quat_x_o
);
  a_stall_only_on_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i)) else $error("spurious input stall");
  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o) else $error("output beat dropped");
  a_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(quat_x_o)) else $error("stalled beat changed");
endmodule

bind euler_to_quaternion_core e2q_checker u_chk (.clk_i(clk_i), .rst_ni(rst_ni),
  .in_stall_o(in_stall_o), .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
  .quat_x_o(quat_x_o));

### tb/testbench.sv
// Testbench for euler_to_quaternion_core: scoreboard with a bit-exact quaternion predictor.
`timescale 1ns / 1ps
module testbench;
  import e2q_pkg::*;

  typedef struct packed {
    logic signed [COMPONENT_BITS-1:0] qx, qy, qz, qw;
  } quat_t;

  function automatic longint sine_q30(logic [31:0] ph);
    logic [1:0] quad;
    longint unsigned r, u2, t, m;
    longint unsigned coefs [7];
    coefs = '{64'd1686629713, 64'd693598668, 64'd85569306, 64'd5026995,
              64'd172272, 64'd3864, 64'd61};
    quad = ph[31:30];
    r = longint'(ph[29:0]);
    if (quad[0]) r = 64'h4000_0000 - r;
    u2 = (r * r) >> 30;
    t = coefs[6];
    for (int k = 5; k >= 0; k--) t = coefs[k] - ((u2 * t) >> 30);
    m = (r * t) >> 30;
    return quad[1] ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint mag_mul(longint a, longint b);
    longint unsigned ua, ub, p;
    ua = a < 0 ? -a : a;
    ub = b < 0 ? -b : b;
    p = (ua * ub) >> 30;
    return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
  endfunction

  function automatic logic [31:0] angle_phase(logic [ANGLE_BITS-1:0] a);
    logic [63:0] v;
    v = {{(64-ANGLE_BITS){a[ANGLE_BITS-1]}}, a};
    if (ANGLE_BITS <= 31) v = v << (31 - ANGLE_BITS);
    else v = v >> (ANGLE_BITS - 31);
    return v[31:0];
  endfunction

  function automatic logic [COMPONENT_BITS-1:0] round_sat(longint v);
    longint unsigned mag, maxpos;
    longint res;
    maxpos = (64'd1 << (COMPONENT_BITS - 1)) - 1;
    mag = v < 0 ? -v : v;
    if (COMPONENT_BITS < 31) mag = (mag + (64'd1 << (30 - COMPONENT_BITS))) >> (31 - COMPONENT_BITS);
    else if (COMPONENT_BITS > 31) mag = mag << (COMPONENT_BITS - 31);
    if (v < 0) res = mag > maxpos + 1 ? -longint'(maxpos + 1) : -longint'(mag);
    else res = mag > maxpos ? longint'(maxpos) : longint'(mag);
    return res[COMPONENT_BITS-1:0];
  endfunction

  function automatic quat_t euler_quat(logic [ANGLE_BITS-1:0] ax, ay, az);
    logic [31:0] px, py, pz;
    longint sx, cx, sy, cy, sz, cz, sc, ss, cs, cc;
    quat_t q;
    px = angle_phase(ax); py = angle_phase(ay); pz = angle_phase(az);
    sx = sine_q30(px); cx = sine_q30(px + 32'h4000_0000);
    sy = sine_q30(py); cy = sine_q30(py + 32'h4000_0000);
    sz = sine_q30(pz); cz = sine_q30(pz + 32'h4000_0000);
    sc = mag_mul(sx, cy); ss = mag_mul(sx, sy);
    cs = mag_mul(cx, sy); cc = mag_mul(cx, cy);
    q.qx = round_sat(mag_mul(sc, cz) - mag_mul(cs, sz));
    q.qy = round_sat(mag_mul(cs, cz) + mag_mul(sc, sz));
    q.qz = round_sat(mag_mul(cc, sz) - mag_mul(ss, cz));
    q.qw = round_sat(mag_mul(cc, cz) + mag_mul(ss, sz));
    return q;
  endfunction

  class quat_board;
    quat_t pending[$];
    int errors;
    function void note_angles(logic [ANGLE_BITS-1:0] ax, ay, az);
      pending.push_back(euler_quat(ax, ay, az));
    endfunction
    function void check_quat(quat_t got);
      quat_t want;
      if (pending.size() == 0) begin
        $display("%0t unexpected beat: got %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.qx !== want.qx) begin
        $display("%0t quat_x exp %0d act %0d", $time, want.qx, got.qx); errors++;
      end
      if (got.qy !== want.qy) begin
        $display("%0t quat_y exp %0d act %0d", $time, want.qy, got.qy); errors++;
      end
      if (got.qz !== want.qz) begin
        $display("%0t quat_z exp %0d act %0d", $time, want.qz, got.qz); errors++;
      end
      if (got.qw !== want.qw) begin
        $display("%0t quat_w exp %0d act %0d", $time, want.qw, got.qw); errors++;
      end
    endfunction
  endclass

  localparam int WATCHDOG = 5000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [ANGLE_BITS-1:0] angle_x_i = '0, angle_y_i = '0, angle_z_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [COMPONENT_BITS-1:0] quat_x_o, quat_y_o, quat_z_o, quat_w_o;

  quat_board board = new();
  bit long_hold = 1'b0;
  bit hold_done = 1'b0;
  int idle_cycles = 0;

  euler_to_quaternion_core dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) board.note_angles(angle_x_i, angle_y_i, angle_z_i);
      if (out_valid_o && !out_stall_i)
        board.check_quat('{quat_x_o, quat_y_o, quat_z_o, quat_w_o});
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // receiver stall pattern, with one long hold-off
  initial begin
    int mode;
    @(posedge rst_ni);
    forever begin
      if (long_hold && !hold_done) begin
        out_stall_i <= 1'b1;
        repeat (60) @(posedge clk_i);
        hold_done = 1'b1;
      end
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(5, 40)) begin
        @(posedge clk_i);
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 3) == 0);
          2: out_stall_i <= 1'($urandom_range(0, 1));
          default: out_stall_i <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  task automatic send_beat(logic [ANGLE_BITS-1:0] ax, ay, az);
    in_valid_i <= 1'b1;
    angle_x_i <= ax; angle_y_i <= ay; angle_z_i <= az;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic pause_sender(int n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  function automatic logic [ANGLE_BITS-1:0] rand_angle();
    case ($urandom_range(0, 5))
      0: return ANGLE_BITS'(1 << (ANGLE_BITS - 1));
      1: return ANGLE_BITS'((1 << (ANGLE_BITS - 1)) - 1);
      2: return ANGLE_BITS'($urandom_range(0, 3) << (ANGLE_BITS - 2));
      3: return ANGLE_BITS'($urandom_range(0, 15) - 8);
      default: return ANGLE_BITS'($urandom());
    endcase
  endfunction

  initial begin
    logic [ANGLE_BITS-1:0] corners [8];
    corners = '{16'h0000, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001,
                16'h4000, 16'hC000, 16'h2000};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < 8; i++) send_beat(corners[i], 16'h0000, 16'h0000);
    for (int i = 0; i < 8; i++) send_beat(16'h0000, corners[i], corners[7 - i]);
    send_beat(16'h8000, 16'h8000, 16'h8000);
    send_beat(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_beat(16'h4000, 16'h4000, 16'h4000);
    send_beat(16'hAAAA, 16'h5555, 16'hAAAA);
    send_beat(16'h5555, 16'hAAAA, 16'h5555);
    pause_sender(1);
    wait (board.pending.size() == 0);
    // long receiver hold while the sender keeps offering
    long_hold = 1'b1;
    for (int i = 0; i < 60; i++) send_beat(rand_angle(), rand_angle(), rand_angle());
    for (int b = 0; b < 640;) begin
      int len;
      len = $urandom_range(1, 30);
      for (int i = 0; i < len; i++) begin
        send_beat(rand_angle(), rand_angle(), rand_angle());
        b++;
      end
      if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 12));
    end
    in_valid_i <= 1'b0;
    wait (board.pending.size() == 0);
    repeat (N_STAGES + 10) @(posedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
